// ----- hdl/btm_pkg.sv -----
package btm_pkg;

  // fixed field widths
  localparam int TEMP_BITS          = 20;
  localparam int CURRENT_BITS       = 16;
  localparam int GAIN_BITS          = 24;
  localparam int HEAT_SHIFT         = 20;
  localparam int COEF_FRAC_BITS_DEF = 24;

  // multiplier digit, bits consumed per cycle
  localparam int DIGIT_BITS = 4;

  // derived datapath widths
  localparam int ISQ_BITS  = 2 * CURRENT_BITS - 1;
  localparam int HEAT_BITS = GAIN_BITS + ISQ_BITS - HEAT_SHIFT;
  localparam int MCAND_BITS = HEAT_BITS + 2;

  // configuration port
  localparam int CFG_ADDR_BITS = 8;
  localparam int CFG_DATA_BITS = 32;

  localparam logic [CFG_ADDR_BITS-1:0] REG_HEATING_GAIN    = 8'd0;
  localparam logic [CFG_ADDR_BITS-1:0] REG_RATE_NODE_ONE   = 8'd1;
  localparam logic [CFG_ADDR_BITS-1:0] REG_RATE_NODE_TWO   = 8'd2;
  localparam logic [CFG_ADDR_BITS-1:0] REG_AMBIENT_TEMP    = 8'd3;
  localparam logic [CFG_ADDR_BITS-1:0] REG_ALERT_THRESHOLD = 8'd4;

  // reset values
  localparam int HEATING_GAIN_RESET    = 216138;
  localparam int RATE_NODE_ONE_RESET   = 1617727;
  localparam int RATE_NODE_TWO_RESET   = 48816;
  localparam int AMBIENT_TEMP_RESET    = 6400;
  localparam int ALERT_THRESHOLD_RESET = 2560;
  localparam int NODE_ONE_RESET        = 15360;
  localparam int NODE_TWO_RESET        = 7680;

  typedef struct packed {
    logic signed [CURRENT_BITS-1:0] cell_current;
    logic signed [TEMP_BITS-1:0]    measured_temp;
  } btm_in_t;

  typedef struct packed {
    logic signed [TEMP_BITS-1:0] model_temp;
    logic                        deviation_alert;
  } btm_out_t;

endpackage

// ----- hdl/btm_serial_mul.sv -----
module btm_serial_mul #(
  parameter int MC_W   = btm_pkg::MCAND_BITS,
  parameter int MULT_W = 28
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic signed [MC_W-1:0]         mcand,
  input  logic        [MULT_W-1:0]       mplier,
  output logic                           done,
  output logic signed [MC_W+MULT_W-1:0]  prod
);
  import btm_pkg::*;

  localparam int SW    = MC_W + DIGIT_BITS;
  localparam int STEPS = MULT_W / DIGIT_BITS;
  localparam int CNT_W = $clog2(STEPS + 1);

  logic signed [MC_W-1:0]   mc_r;
  logic        [MULT_W-1:0] mp_r, mp_nxt;
  logic signed [MC_W-1:0]   hi_r, hi_nxt;
  logic        [MULT_W-1:0] lo_r, lo_nxt;
  logic        [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic                     busy_r, busy_nxt;
  logic                     done_r, done_nxt;

  logic signed [SW-1:0] mc_ext, dig_ext, part, hi_ext, sum;

  // one digit of the multiplier per cycle, lsb first
  assign mc_ext  = SW'(mc_r);
  assign dig_ext = SW'(mp_r[DIGIT_BITS-1:0]);
  assign hi_ext  = SW'(hi_r);
  assign part    = mc_ext * dig_ext;
  assign sum     = hi_ext + part;

  // step control
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(STEPS);
    end else if (busy_r) begin
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // accumulator and shift registers
  always_comb begin
    hi_nxt = hi_r;
    lo_nxt = lo_r;
    mp_nxt = mp_r;
    if (start) begin
      hi_nxt = '0;
      lo_nxt = '0;
      mp_nxt = mplier;
    end else if (busy_r) begin
      hi_nxt = sum[SW-1:DIGIT_BITS];
      lo_nxt = {sum[DIGIT_BITS-1:0], lo_r[MULT_W-1:DIGIT_BITS]};
      mp_nxt = mp_r >> DIGIT_BITS;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mc_r <= mcand;
    end
    hi_r <= hi_nxt;
    lo_r <= lo_nxt;
    mp_r <= mp_nxt;
  end

  assign done = done_r;
  assign prod = {hi_r, lo_r};

endmodule

// ----- hdl/battery_thermal_model_monitor.sv -----
// a new request is held off until the shared 4-bit serial multiplier has formed current squared,
//   the heat term and both node updates in turn, and the result is in the output register
// a finished result waits in the output register while the next request is taken
// reset (synchronous, rst_n low): registers return to their defaults, node one 60 C,
//   node two 30 C, no result pending
module battery_thermal_model_monitor #(
  parameter int COEF_FRAC_BITS = btm_pkg::COEF_FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  btm_pkg::btm_in_t                    in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output btm_pkg::btm_out_t                   out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [btm_pkg::CFG_ADDR_BITS-1:0]   cfg_addr,
  input  logic [btm_pkg::CFG_DATA_BITS-1:0]   cfg_data
);
  import btm_pkg::*;

  localparam int RW     = COEF_FRAC_BITS + 1;
  localparam int MC_W   = MCAND_BITS;
  localparam int MP_RAW = (RW > GAIN_BITS) ? RW : GAIN_BITS;
  localparam int MULT_W = ((MP_RAW + DIGIT_BITS - 1) / DIGIT_BITS) * DIGIT_BITS;
  localparam int PW     = MC_W + MULT_W;
  localparam int SH_W   = PW - COEF_FRAC_BITS;
  localparam int SUM_W  = SH_W + 1;

  localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'(2 ** (TEMP_BITS - 1) - 1);
  localparam logic signed [SUM_W-1:0] SAT_LO = ~SAT_HI;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SQUARE = 3'd1;
  localparam logic [2:0] ST_HEAT   = 3'd2;
  localparam logic [2:0] ST_NODE1  = 3'd3;
  localparam logic [2:0] ST_NODE2  = 3'd4;
  localparam logic [2:0] ST_FINISH = 3'd5;

  logic [2:0] state_r, state_nxt;

  logic        [GAIN_BITS-1:0] gain_r;
  logic        [RW-1:0]        rate1_r, rate2_r;
  logic signed [TEMP_BITS-1:0] amb_r;
  logic        [TEMP_BITS-2:0] thr_r;
  logic signed [TEMP_BITS-1:0] n1_r, n2_r;
  logic signed [TEMP_BITS-1:0] meas_r;
  btm_out_t                    out_data_r;
  logic                        out_valid_r;

  logic                     mul_start, mul_done;
  logic signed [MC_W-1:0]   mul_mcand;
  logic        [MULT_W-1:0] mul_mplier;
  logic signed [PW-1:0]     mul_prod;

  logic signed [CURRENT_BITS:0]   cur_ext, cur_neg;
  logic        [CURRENT_BITS-1:0] cur_abs;
  logic signed [MC_W-1:0]         heat_ext, amb_ext, n1_ext, n2_ext, d1, d2;
  logic signed [SH_W-1:0]         prod_sh;
  logic signed [SUM_W-1:0]        node_sum;
  logic signed [TEMP_BITS-1:0]    node_sel, node_sat;
  logic signed [TEMP_BITS:0]      gap;
  logic        [TEMP_BITS:0]      gap_abs;
  logic                           in_take, out_free;

  btm_serial_mul #(
    .MC_W   (MC_W),
    .MULT_W (MULT_W)
  ) u_mul (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (mul_start),
    .mcand  (mul_mcand),
    .mplier (mul_mplier),
    .done   (mul_done),
    .prod   (mul_prod)
  );

  // handshakes
  assign in_stall  = (state_r != ST_IDLE);
  assign in_take   = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // magnitude of the current, squaring ignores its sign
  assign cur_ext = (CURRENT_BITS + 1)'(in_data.cell_current);
  assign cur_neg = -cur_ext;
  assign cur_abs = cur_ext[CURRENT_BITS] ? cur_neg[CURRENT_BITS-1:0]
                                         : cur_ext[CURRENT_BITS-1:0];

  // node differences
  assign heat_ext = MC_W'(mul_prod[HEAT_SHIFT +: HEAT_BITS]);
  assign amb_ext  = MC_W'(amb_r);
  assign n1_ext   = MC_W'(n1_r);
  assign n2_ext   = MC_W'(n2_r);
  assign d1       = heat_ext + amb_ext - n1_ext;
  assign d2       = n1_ext - n2_ext;

  // node update: floor shift of the product, add, clamp
  assign prod_sh  = mul_prod[PW-1:COEF_FRAC_BITS];
  assign node_sel = (state_r == ST_NODE1) ? n1_r : n2_r;
  assign node_sum = SUM_W'(node_sel) + SUM_W'(prod_sh);

  always_comb begin
    if (node_sum > SAT_HI) begin
      node_sat = SAT_HI[TEMP_BITS-1:0];
    end else if (node_sum < SAT_LO) begin
      node_sat = SAT_LO[TEMP_BITS-1:0];
    end else begin
      node_sat = node_sum[TEMP_BITS-1:0];
    end
  end

  // deviation between measured and modelled temperature
  assign gap     = (TEMP_BITS + 1)'(meas_r) - (TEMP_BITS + 1)'(n2_r);
  assign gap_abs = gap[TEMP_BITS] ? (TEMP_BITS + 1)'(-gap) : (TEMP_BITS + 1)'(gap);

  // sequencer over the shared multiplier
  always_comb begin
    state_nxt  = state_r;
    mul_start  = 1'b0;
    mul_mcand  = '0;
    mul_mplier = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_take) begin
          mul_start  = 1'b1;
          mul_mcand  = MC_W'(cur_abs);
          mul_mplier = MULT_W'(cur_abs);
          state_nxt  = ST_SQUARE;
        end
      end
      ST_SQUARE: begin
        if (mul_done) begin
          mul_start  = 1'b1;
          mul_mcand  = MC_W'(mul_prod[ISQ_BITS-1:0]);
          mul_mplier = MULT_W'(gain_r);
          state_nxt  = ST_HEAT;
        end
      end
      ST_HEAT: begin
        if (mul_done) begin
          mul_start  = 1'b1;
          mul_mcand  = d1;
          mul_mplier = MULT_W'(rate1_r);
          state_nxt  = ST_NODE1;
        end
      end
      ST_NODE1: begin
        if (mul_done) begin
          mul_start  = 1'b1;
          mul_mcand  = d2;
          mul_mplier = MULT_W'(rate2_r);
          state_nxt  = ST_NODE2;
        end
      end
      ST_NODE2: begin
        if (mul_done) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control state, configuration and model nodes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      gain_r      <= GAIN_BITS'(HEATING_GAIN_RESET);
      rate1_r     <= RW'(RATE_NODE_ONE_RESET);
      rate2_r     <= RW'(RATE_NODE_TWO_RESET);
      amb_r       <= TEMP_BITS'(AMBIENT_TEMP_RESET);
      thr_r       <= (TEMP_BITS - 1)'(ALERT_THRESHOLD_RESET);
      n1_r        <= TEMP_BITS'(NODE_ONE_RESET);
      n2_r        <= TEMP_BITS'(NODE_TWO_RESET);
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_FINISH && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_addr)
          REG_HEATING_GAIN:    gain_r  <= cfg_data[GAIN_BITS-1:0];
          REG_RATE_NODE_ONE:   rate1_r <= cfg_data[RW-1:0];
          REG_RATE_NODE_TWO:   rate2_r <= cfg_data[RW-1:0];
          REG_AMBIENT_TEMP:    amb_r   <= cfg_data[TEMP_BITS-1:0];
          REG_ALERT_THRESHOLD: thr_r   <= cfg_data[TEMP_BITS-2:0];
          default: begin
          end
        endcase
      end
      if (state_r == ST_NODE1 && mul_done) begin
        n1_r <= node_sat;
      end
      if (state_r == ST_NODE2 && mul_done) begin
        n2_r <= node_sat;
      end
    end
  end

  // request and result payload
  always_ff @(posedge clk) begin
    if (in_take) begin
      meas_r <= in_data.measured_temp;
    end
    if (state_r == ST_FINISH && out_free) begin
      out_data_r.model_temp      <= n2_r;
      out_data_r.deviation_alert <= (gap_abs > (TEMP_BITS + 1)'(thr_r));
    end
  end

  // a taken request always starts the squaring pass
  a_take_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_take |=> (state_r == ST_SQUARE))
    else $error("request taken but squaring pass not started");

  // multiplier completion only seen while a product is awaited
  a_done_expected: assert property (@(posedge clk) disable iff (!rst_n)
    mul_done |-> (state_r == ST_SQUARE || state_r == ST_HEAT ||
                  state_r == ST_NODE1 || state_r == ST_NODE2))
    else $error("multiplier finished outside a product state");

  // a finished result is presented and the block goes idle
  a_finish_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FINISH && out_free) |=> (out_valid_r && state_r == ST_IDLE))
    else $error("finished result not loaded into output register");

  // a pending result is never overwritten
  a_finish_waits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FINISH && out_valid_r && out_stall) |=> (state_r == ST_FINISH))
    else $error("result finished while output register still occupied");

endmodule
